// ===== src/greedy_box_nms_defines.svh =====
// Assertion macros for the greedy box suppression block.
// No dependencies; included by the top level.
`ifndef GREEDY_BOX_NMS_DEFINES_SVH
`define GREEDY_BOX_NMS_DEFINES_SVH

// same-cycle implication
`define GBN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbn assertion failed");

// next-cycle implication
`define GBN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbn assertion failed");

`endif

// ===== src/gbn_pkg.sv =====
// Shared constants, register map and controller/datapath structs for the
// greedy box suppression block. No dependencies.
package gbn_pkg;

  localparam int MAX_KEPT  = 1024;
  localparam int KEPT_AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W     = $clog2(MAX_KEPT + 1);
  localparam int COORD_W   = 16;
  localparam int AREA_W    = 2 * (COORD_W + 1);
  localparam int ENTRY_W   = 4 * COORD_W + AREA_W;
  localparam int BOX_CNT_W = 16;

  localparam int APB_AW = 4;
  localparam logic [1:0] REG_THRESH_NUM = 2'd0;
  localparam logic [1:0] REG_THRESH_DEN = 2'd1;
  localparam logic [1:0] REG_MAX_BOXES  = 2'd2;

  localparam logic [7:0]  THRESH_NUM_RST = 8'd7;
  localparam logic [7:0]  THRESH_DEN_RST = 8'd10;
  localparam logic [15:0] MAX_BOXES_RST  = 16'd6000;

  typedef struct packed {
    logic               load;
    logic               calc_area;
    logic               rd_en;
    logic [KEPT_AW-1:0] rd_addr;
    logic               wr_en;
    logic [KEPT_AW-1:0] wr_addr;
  } gbn_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic suppressed;
  } gbn_stat_t;

endpackage

// ===== src/greedy_box_nms.sv =====
// Greedy box suppression, top level: register port, controller, datapath.
// Request to result: area, scan of the kept boxes (at most 1024 in the set),
// pipeline drain, result; scan and drain are skipped when none is compared.
// One request at a time; the next is taken in the cycle after the result is
// registered. The single read port of the kept-box memory sets the scan rate.
// Synchronous reset clears counters and control; the kept store is not swept.
`include "greedy_box_nms_defines.svh"

module greedy_box_nms (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               first_box,
  input  logic signed [15:0] x_min,
  input  logic signed [15:0] y_min,
  input  logic signed [15:0] x_max,
  input  logic signed [15:0] y_max,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               keep,
  output logic               store_full,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [gbn_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gbn_pkg::*;

  logic [7:0]  thresh_num;
  logic [7:0]  thresh_den;
  logic [15:0] max_boxes;
  logic        wr_fire;

  gbn_cmd_t  cmd;
  gbn_stat_t stat;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_num <= THRESH_NUM_RST;
      thresh_den <= THRESH_DEN_RST;
      max_boxes  <= MAX_BOXES_RST;
    end else if (wr_fire) begin
      case (paddr[3:2])
        REG_THRESH_NUM: thresh_num <= pwdata[7:0];
        REG_THRESH_DEN: thresh_den <= pwdata[7:0];
        REG_MAX_BOXES:  max_boxes  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESH_NUM: prdata = {24'b0, thresh_num};
      REG_THRESH_DEN: prdata = {24'b0, thresh_den};
      REG_MAX_BOXES:  prdata = {16'b0, max_boxes};
      default:        prdata = '0;
    endcase
  end

  gbn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .first_box  (first_box),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .keep       (keep),
    .store_full (store_full),
    .max_boxes  (max_boxes),
    .cmd        (cmd),
    .stat       (stat)
  );

  gbn_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .thresh_num (thresh_num),
    .thresh_den (thresh_den),
    .x_min      (x_min),
    .y_min      (y_min),
    .x_max      (x_max),
    .y_max      (y_max)
  );

  `GBN_ASSERT_NOW(a_full_implies_keep, clk, rst, out_valid && store_full, keep)
  `GBN_ASSERT_NEXT(a_one_request, clk, rst, in_valid && in_ready, !in_ready)
  `GBN_ASSERT_NOW(a_busy_blocks_input, clk, rst, stat.pipe_busy, !in_ready)
  `GBN_ASSERT_NOW(a_no_read_on_write, clk, rst, cmd.wr_en, !cmd.rd_en && !stat.pipe_busy)

endmodule

// ===== src/gbn_ctrl.sv =====
// Controller: request sequencing, kept/box counters, scan of the kept store
// and the result register. Depends on gbn_pkg.
module gbn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               first_box,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               keep,
  output logic               store_full,
  input  logic [15:0]        max_boxes,
  output gbn_pkg::gbn_cmd_t  cmd,
  input  gbn_pkg::gbn_stat_t stat
);
  import gbn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     kept_count;
  logic [BOX_CNT_W-1:0] box_count;
  logic [CNT_W-1:0]     idx;
  logic                 live;

  logic                 accept;
  logic                 fire;
  logic                 survive;
  logic                 full;
  logic [BOX_CNT_W-1:0] box_count_eff;

  assign in_ready      = (state == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign fire          = (state == ST_FINISH) && (!out_valid || out_ready);
  assign survive       = live && !stat.suppressed;
  assign full          = (kept_count == CNT_W'(MAX_KEPT));
  assign box_count_eff = first_box ? '0 : box_count;

  always_comb begin
    cmd.load      = accept;
    cmd.calc_area = (state == ST_AREA);
    cmd.rd_en     = (state == ST_SCAN);
    cmd.rd_addr   = idx[KEPT_AW-1:0];
    cmd.wr_en     = fire && survive && !full;
    cmd.wr_addr   = kept_count[KEPT_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      kept_count <= '0;
      box_count  <= '0;
      idx        <= '0;
      live       <= 1'b0;
      out_valid  <= 1'b0;
      keep       <= 1'b0;
      store_full <= 1'b0;
    end else begin
      if (out_ready && !fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (first_box) begin
              kept_count <= '0;
              box_count  <= '0;
            end
            live  <= (box_count_eff < max_boxes);
            state <= ST_AREA;
          end
        end
        ST_AREA: begin
          idx <= '0;
          if (live && (kept_count != '0)) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_SCAN: begin
          idx <= idx + 1'b1;
          if (idx + 1'b1 == kept_count) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!stat.pipe_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fire) begin
            out_valid  <= 1'b1;
            keep       <= survive;
            store_full <= survive && full;
            if (survive && !full) begin
              kept_count <= kept_count + 1'b1;
            end
            if (box_count != '1) begin
              box_count <= box_count + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/gbn_datapath.sv =====
// Datapath: box and area registers, kept-box memory and the pipelined
// exact IoU test against one kept box per cycle. Depends on gbn_pkg.
module gbn_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  gbn_pkg::gbn_cmd_t         cmd,
  output gbn_pkg::gbn_stat_t        stat,
  input  logic [7:0]                thresh_num,
  input  logic [7:0]                thresh_den,
  input  logic signed [15:0]        x_min,
  input  logic signed [15:0]        y_min,
  input  logic signed [15:0]        x_max,
  input  logic signed [15:0]        y_max
);
  import gbn_pkg::*;

  logic signed [COORD_W-1:0] bx0, by0, bx1, by1;
  logic signed [COORD_W:0]   dx, dy;
  logic signed [AREA_W-1:0]  area;

  logic [ENTRY_W-1:0] mem [MAX_KEPT];
  logic [ENTRY_W-1:0] rd_data;

  logic v1, v2, v3, v4, v5;

  // stage 1: overlap extents
  logic signed [COORD_W-1:0] kx0, ky0, kx1, ky1;
  logic signed [COORD_W-1:0] ix0, iy0, ix1, iy1;
  logic signed [COORD_W:0]   w_raw, h_raw;
  logic [COORD_W-1:0]        w_q, h_q;
  logic signed [AREA_W-1:0]  ka1_q;

  // stage 2: intersection
  logic [2*COORD_W-1:0]      inter_q;
  logic signed [AREA_W-1:0]  ka2_q;

  // stage 3: union and inter * den
  logic signed [35:0]        uni_c;
  logic signed [35:0]        uni_q;
  logic [39:0]               prod_d_q;

  // stage 4: num * union
  logic signed [44:0]        prod_n_q;
  logic [39:0]               prod_d4_q;
  logic                      uni_zero_q, uni_neg_q;

  logic hit;
  logic sup;

  assign dx = (COORD_W+1)'(bx1) - (COORD_W+1)'(bx0);
  assign dy = (COORD_W+1)'(by1) - (COORD_W+1)'(by0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bx0 <= x_min;
      by0 <= y_min;
      bx1 <= x_max;
      by1 <= y_max;
    end
    if (cmd.calc_area) begin
      area <= dx * dy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= {area, by1, bx1, by0, bx0};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  always_comb begin
    kx0   = signed'(rd_data[COORD_W-1:0]);
    ky0   = signed'(rd_data[2*COORD_W-1:COORD_W]);
    kx1   = signed'(rd_data[3*COORD_W-1:2*COORD_W]);
    ky1   = signed'(rd_data[4*COORD_W-1:3*COORD_W]);
    ix0   = (bx0 > kx0) ? bx0 : kx0;
    iy0   = (by0 > ky0) ? by0 : ky0;
    ix1   = (bx1 < kx1) ? bx1 : kx1;
    iy1   = (by1 < ky1) ? by1 : ky1;
    w_raw = (COORD_W+1)'(ix1) - (COORD_W+1)'(ix0);
    h_raw = (COORD_W+1)'(iy1) - (COORD_W+1)'(iy0);
  end

  assign uni_c = 36'(area) + 36'(ka2_q) - signed'({4'b0, inter_q});

  assign hit = uni_zero_q
            || (!uni_neg_q && (signed'({5'b0, prod_d4_q}) > prod_n_q));

  always_ff @(posedge clk) begin
    w_q       <= w_raw[COORD_W] ? '0 : w_raw[COORD_W-1:0];
    h_q       <= h_raw[COORD_W] ? '0 : h_raw[COORD_W-1:0];
    ka1_q     <= signed'(rd_data[ENTRY_W-1:4*COORD_W]);
    inter_q   <= w_q * h_q;
    ka2_q     <= ka1_q;
    uni_q     <= uni_c;
    prod_d_q  <= inter_q * thresh_den;
    prod_n_q  <= signed'({1'b0, thresh_num}) * uni_q;
    prod_d4_q <= prod_d_q;
    uni_zero_q <= (uni_q == '0);
    uni_neg_q  <= uni_q[35];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      sup <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (cmd.load) begin
        sup <= 1'b0;
      end else if (v5 && hit) begin
        sup <= 1'b1;
      end
    end
  end

  assign stat.pipe_busy  = v1 || v2 || v3 || v4 || v5;
  assign stat.suppressed = sup;

endmodule
